/* rtl/scs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the clause splitter: field widths, register
// indexes, the queue entry kind and the configuration write group.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int MAX_CLAUSE_LITERALS_DEF = 16;
  localparam int LITERAL_BITS_DEF        = 25;

  localparam int VAR_BITS       = 24;
  localparam int CLAUSE_BITS    = 32;
  localparam int WIDTH_BITS     = 5;
  localparam int MIN_WIDTH      = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [VAR_BITS-1:0] VAR_MAX = '1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHEST_VAR  = 2'd1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_CLOSE = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic                      en;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [VAR_BITS-1:0]       data;
  } cfg_wr_t;

endpackage

/* rtl/sat_clause_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_clause_splitter
// Splits CNF clauses from a literal stream into clauses of bounded width.
// ----------------------------------------------------------------------------
// Literals arrive one per transfer; a zero literal closes the clause. A
// nonzero literal is buffered and produces nothing. A closing zero starts
// the emit sequencer, which sends n+1 output tokens for a clause of n <= k
// literals, more for a split chain (each link adds a fresh variable, its
// negation and a zero). The sequencer, emitting one token per cycle unless
// the output stalls, sets the rate; a two-entry queue in front keeps input
// transfers flowing meanwhile, and an output register parts the result
// side. Up to MAX_CLAUSE_LITERALS literals are kept per clause; later ones
// are dropped and the clause is flagged as truncated. Configuration writes
// are taken at any time but are meant for when the block is idle; writing
// the highest input variable also restarts fresh-variable numbering from
// it.
// ----------------------------------------------------------------------------
module sat_clause_splitter #(
  parameter int MAX_CLAUSE_LITERALS = scs_pkg::MAX_CLAUSE_LITERALS_DEF,
  parameter int LITERAL_BITS        = scs_pkg::LITERAL_BITS_DEF,
  localparam int IN_DATA_BITS  = ((LITERAL_BITS + 7) / 8) * 8,
  localparam int OUT_FIELD_BITS = LITERAL_BITS + scs_pkg::VAR_BITS + scs_pkg::CLAUSE_BITS,
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_DATA_BITS-1:0]             in_tdata,   // literal
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_DATA_BITS-1:0]            out_tdata,  // out_literal, variable_total,
                                                          // clause_total
  output logic                                out_tlast,  // run_last
  output logic [1:0]                          out_tuser,  // clause_truncated,
                                                          // variable_overflow
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [scs_pkg::VAR_BITS-1:0]        cfg_data
);
  import scs_pkg::*;

  cfg_wr_t                 cfg_wr;
  logic                    push_valid;
  logic                    push_ready;
  logic [LITERAL_BITS:0]   push_data;
  logic                    q_valid;
  logic                    q_pop;
  logic [LITERAL_BITS:0]   q_data;
  logic [LITERAL_BITS-1:0] out_literal;
  logic [VAR_BITS-1:0]     out_var_total;
  logic [CLAUSE_BITS-1:0]  out_clause_total;
  logic                    out_truncated;
  logic                    out_overflow;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  scs_front #(
    .LITERAL_BITS (LITERAL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .lit_valid  (in_tvalid),
    .lit_ready  (in_tready),
    .lit_data   (in_tdata[LITERAL_BITS-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  scs_queue #(
    .WIDTH (LITERAL_BITS + 1)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  scs_back #(
    .MAX_CLAUSE_LITERALS (MAX_CLAUSE_LITERALS),
    .LITERAL_BITS        (LITERAL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_wr),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_literal      (out_literal),
    .out_last         (out_tlast),
    .out_var_total    (out_var_total),
    .out_clause_total (out_clause_total),
    .out_truncated    (out_truncated),
    .out_overflow     (out_overflow)
  );

  assign out_tdata = OUT_DATA_BITS'({out_clause_total, out_var_total, out_literal});
  assign out_tuser = {out_overflow, out_truncated};

endmodule

/* rtl/scs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_front
// Input stage: takes literals off the stream, tags each as a store or a
// clause close, and pushes the tagged entry into the queue.
// ----------------------------------------------------------------------------
module scs_front #(
  parameter int LITERAL_BITS = scs_pkg::LITERAL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    lit_valid,
  output logic                    lit_ready,
  input  logic [LITERAL_BITS-1:0] lit_data,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [LITERAL_BITS:0]   push_data   // {kind, literal}
);
  import scs_pkg::*;

  logic                    hold_valid_r, hold_valid_nxt;
  op_kind_t                hold_kind_r;
  logic [LITERAL_BITS-1:0] hold_lit_r;
  logic                    take;

  assign lit_ready  = !hold_valid_r || push_ready;
  assign take       = lit_valid && lit_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = {hold_kind_r, hold_lit_r};

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_lit_r  <= lit_data;
      hold_kind_r <= (lit_data == '0) ? OP_CLOSE : OP_STORE;
    end
  end

endmodule

/* rtl/scs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_queue
// Short FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module scs_queue #(
  parameter int WIDTH = scs_pkg::LITERAL_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import scs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // depth is a power of two, pointers wrap by overflow
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/scs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_back
// Clause buffer and emit sequencer: stores literals, and on a clause close
// walks the buffer emitting either the clause itself or a chain of clauses
// joined by fresh variables. Holds the registers and the output stage.
// ----------------------------------------------------------------------------
module scs_back #(
  parameter int MAX_CLAUSE_LITERALS = scs_pkg::MAX_CLAUSE_LITERALS_DEF,
  parameter int LITERAL_BITS        = scs_pkg::LITERAL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  scs_pkg::cfg_wr_t                 cfg_wr,
  input  logic                             q_valid,
  input  logic [LITERAL_BITS:0]            q_data,    // {kind, literal}
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [LITERAL_BITS-1:0]          out_literal,
  output logic                             out_last,
  output logic [scs_pkg::VAR_BITS-1:0]     out_var_total,
  output logic [scs_pkg::CLAUSE_BITS-1:0]  out_clause_total,
  output logic                             out_truncated,
  output logic                             out_overflow
);
  import scs_pkg::*;

  localparam int FB = $clog2(MAX_CLAUSE_LITERALS + 1);
  localparam int IB = $clog2(MAX_CLAUSE_LITERALS);
  localparam int WB = WIDTH_BITS;
  localparam int CW = ((FB > WB) ? FB : WB) + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LIT   = 5'b00010,
    ST_FRESH = 5'b00100,
    ST_ZERO  = 5'b01000,
    ST_NEG   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LITERAL_BITS-1:0] store_r [MAX_CLAUSE_LITERALS];
  logic [LITERAL_BITS-1:0] store_q;
  logic [FB-1:0]           fill_r, fill_nxt;
  logic                    trunc_r, trunc_nxt;
  logic [IB-1:0]           idx_r, idx_nxt;
  logic [FB-1:0]           seg_r, seg_nxt;
  logic [FB-1:0]           left_r, left_nxt;
  logic                    more_r, more_nxt;
  logic [VAR_BITS-1:0]     nv_r, nv_nxt;
  logic                    sat_r, sat_nxt;
  logic [CLAUSE_BITS-1:0]  cls_r, cls_nxt;
  logic [WB-1:0]           tw_r, tw_nxt;
  logic                    st_we;

  logic                    out_valid_r, out_valid_nxt;
  logic [LITERAL_BITS-1:0] out_lit_r;
  logic                    out_last_r;
  logic [VAR_BITS-1:0]     out_var_r;
  logic [CLAUSE_BITS-1:0]  out_cls_r;
  logic                    out_trunc_r;
  logic                    out_sat_r;

  logic                    adv;
  logic                    emit;
  logic                    emit_last;
  logic [LITERAL_BITS-1:0] emit_lit;
  logic [LITERAL_BITS-1:0] q_lit;
  op_kind_t                q_kind;
  logic [WB-1:0]           k_eff;
  logic [CW-1:0]           k_ext;
  logic [CW-1:0]           fill_ext;
  logic [CW-1:0]           left_ext;
  logic [CW-1:0]           take;

  assign q_lit    = q_data[LITERAL_BITS-1:0];
  assign q_kind   = op_kind_t'(q_data[LITERAL_BITS]);
  assign store_q  = store_r[idx_r];
  assign adv      = !out_valid_r || out_ready;

  // widths below three act as three
  assign k_eff    = (tw_r < WB'(MIN_WIDTH)) ? WB'(MIN_WIDTH) : tw_r;
  assign k_ext    = CW'(k_eff);
  assign fill_ext = CW'(fill_r);
  assign left_ext = CW'(left_r);
  // middle links carry k-2 literals, the closing link the rest (at most k-1)
  assign take     = (left_ext > k_ext - CW'(1)) ? k_ext - CW'(2) : left_ext;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    trunc_nxt = trunc_r;
    idx_nxt   = idx_r;
    seg_nxt   = seg_r;
    left_nxt  = left_r;
    more_nxt  = more_r;
    nv_nxt    = nv_r;
    sat_nxt   = sat_r;
    cls_nxt   = cls_r;
    tw_nxt    = tw_r;
    q_pop     = 1'b0;
    st_we     = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_lit  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_kind == OP_STORE) begin
            if (fill_r < FB'(MAX_CLAUSE_LITERALS)) begin
              st_we    = 1'b1;
              fill_nxt = fill_r + FB'(1);
            end else begin
              trunc_nxt = 1'b1;
            end
          end else begin
            idx_nxt = '0;
            if (fill_ext > k_ext) begin
              // head link: k-1 literals then the first fresh variable
              seg_nxt   = FB'(k_ext - CW'(1));
              left_nxt  = FB'(fill_ext - (k_ext - CW'(1)));
              more_nxt  = 1'b1;
              state_nxt = ST_LIT;
            end else begin
              seg_nxt   = fill_r;
              left_nxt  = '0;
              more_nxt  = 1'b0;
              state_nxt = (fill_r == '0) ? ST_ZERO : ST_LIT;
            end
          end
        end
      end
      ST_LIT: begin
        if (adv) begin
          emit     = 1'b1;
          emit_lit = store_q;
          idx_nxt  = idx_r + IB'(1);
          seg_nxt  = seg_r - FB'(1);
          if (seg_r == FB'(1)) begin
            state_nxt = more_r ? ST_FRESH : ST_ZERO;
          end
        end
      end
      ST_FRESH: begin
        if (adv) begin
          if (nv_r == VAR_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            nv_nxt = nv_r + VAR_BITS'(1);
          end
          emit      = 1'b1;
          emit_lit  = LITERAL_BITS'(nv_nxt);
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (adv) begin
          emit = 1'b1;
          if (cls_r != '1) begin
            cls_nxt = cls_r + CLAUSE_BITS'(1);
          end
          if (left_r != '0) begin
            state_nxt = ST_NEG;
          end else begin
            emit_last = 1'b1;
            fill_nxt  = '0;
            trunc_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NEG: begin
        if (adv) begin
          emit      = 1'b1;
          emit_lit  = '0 - LITERAL_BITS'(nv_r);
          seg_nxt   = FB'(take);
          left_nxt  = FB'(left_ext - take);
          more_nxt  = (left_ext != take);
          state_nxt = ST_LIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        REG_TARGET_WIDTH: tw_nxt = cfg_wr.data[WB-1:0];
        REG_HIGHEST_VAR:  nv_nxt = cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      trunc_r     <= 1'b0;
      idx_r       <= '0;
      seg_r       <= '0;
      left_r      <= '0;
      more_r      <= 1'b0;
      nv_r        <= '0;
      sat_r       <= 1'b0;
      cls_r       <= '0;
      tw_r        <= WB'(MIN_WIDTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      trunc_r     <= trunc_nxt;
      idx_r       <= idx_nxt;
      seg_r       <= seg_nxt;
      left_r      <= left_nxt;
      more_r      <= more_nxt;
      nv_r        <= nv_nxt;
      sat_r       <= sat_nxt;
      cls_r       <= cls_nxt;
      tw_r        <= tw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_r[fill_r[IB-1:0]] <= q_lit;
    end
  end

  // token carries the totals as they stand after it
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_lit_r   <= emit_lit;
      out_last_r  <= emit_last;
      out_var_r   <= nv_nxt;
      out_cls_r   <= cls_nxt;
      out_trunc_r <= trunc_r;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_literal      = out_lit_r;
  assign out_last         = out_last_r;
  assign out_var_total    = out_var_r;
  assign out_clause_total = out_cls_r;
  assign out_truncated    = out_trunc_r;
  assign out_overflow     = out_sat_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FB'(MAX_CLAUSE_LITERALS))
    else $error("clause buffer fill beyond depth");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |=> sat_r)
    else $error("saturation mark dropped");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ZERO && adv && left_r == '0)
      |=> (state_r == ST_IDLE && fill_r == '0 && !trunc_r && out_valid_r && out_last_r))
    else $error("final token did not close the clause");

endmodule
